// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

  localparam int FIELD_W     = 16;
  localparam int MAG_W       = 32;
  localparam int DEN_W       = 31;
  localparam int RES_NUM_W   = 34;
  localparam int GCD_STEPS   = 64;
  localparam int DIV_STEPS   = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;
  localparam logic [2:0] CMD_INC = 3'd5;
  localparam logic [2:0] CMD_DEC = 3'd6;
  localparam logic [2:0] CMD_RSV = 3'd7;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef struct packed {
    logic       neg;
    logic [1:0] cmp;
    logic       status;
  } sb_t;

endpackage

// ===== sv/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// Exact arithmetic on two signed fractions: add, subtract, multiply, divide,
// compare, increment and decrement of a. Results are fully reduced with a
// positive denominator (increment and decrement are not reduced); a zero
// denominator, division by zero or an unused command gives status 1 with 0/0.
// Fully pipelined: one beat accepted per cycle while the output is not stalled, with
// 100 register stages: three front stages, 64 binary gcd stages, 32 divider stages
// and the output register.
// A stall on the output holds the whole pipeline.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command, a_num, a_den, b_num, b_den
  input  logic [rau_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // res_num, res_den, cmp_code, status
  output logic [rau_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rau_pkg::*;

  localparam int EFF_W = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
  localparam int SH    = FIELD_W - EFF_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: capture and sign-extend
  logic                      v1_r;
  logic [2:0]                cmd1_r;
  logic signed [FIELD_W-1:0] an1_r, ad1_r, bn1_r, bd1_r;
  logic [FIELD_W-1:0]        f_an, f_ad, f_bn, f_bd;

  assign f_an = in_tdata[18:3];
  assign f_ad = in_tdata[34:19];
  assign f_bn = in_tdata[50:35];
  assign f_bd = in_tdata[66:51];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= in_tdata[2:0];
      an1_r  <= $signed(f_an << SH) >>> SH;
      ad1_r  <= $signed(f_ad << SH) >>> SH;
      bn1_r  <= $signed(f_bn << SH) >>> SH;
      bd1_r  <= $signed(f_bd << SH) >>> SH;
    end
  end

  // stage 2: products
  logic                      v2_r;
  logic [2:0]                cmd2_r;
  logic signed [FIELD_W-1:0] an2_r, ad2_r, bn2_r, bd2_r;
  logic signed [MAG_W-1:0]   p_ab_r, p_ba_r, p_nn_r, p_dd_r, p_dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      an2_r  <= an1_r;
      ad2_r  <= ad1_r;
      bn2_r  <= bn1_r;
      bd2_r  <= bd1_r;
      p_ab_r <= an1_r * bd1_r;
      p_ba_r <= bn1_r * ad1_r;
      p_nn_r <= an1_r * bn1_r;
      p_dd_r <= ad1_r * bd1_r;
      p_dn_r <= ad1_r * bn1_r;
    end
  end

  // stage 3: select, sign and magnitude, compare
  logic signed [MAG_W:0]   n3, diff3;
  logic signed [MAG_W-1:0] d3;
  logic [MAG_W:0]          nabs3;
  logic [MAG_W-1:0]        dabs3;
  logic                    err3, red3;
  logic [1:0]              cmp3;
  sb_t                     sb3_nxt;
  logic [MAG_W-1:0]        u3_nxt, w3_nxt, n3_nxt, d3_nxt;

  always_comb begin
    err3 = (cmd2_r > CMD_DEC) || (ad2_r == '0) ||
           (cmd2_r <= CMD_CMP && bd2_r == '0) ||
           (cmd2_r == CMD_DIV && bn2_r == '0);
    red3 = 1'b0;
    unique case (cmd2_r)
      CMD_ADD: begin
        n3 = {p_ab_r[MAG_W-1], p_ab_r} + {p_ba_r[MAG_W-1], p_ba_r};
        d3 = p_dd_r;
        red3 = 1'b1;
      end
      CMD_SUB: begin
        n3 = {p_ab_r[MAG_W-1], p_ab_r} - {p_ba_r[MAG_W-1], p_ba_r};
        d3 = p_dd_r;
        red3 = 1'b1;
      end
      CMD_MUL: begin
        n3 = {p_nn_r[MAG_W-1], p_nn_r};
        d3 = p_dd_r;
        red3 = 1'b1;
      end
      CMD_DIV: begin
        n3 = {p_ab_r[MAG_W-1], p_ab_r};
        d3 = p_dn_r;
        red3 = 1'b1;
      end
      CMD_INC: begin
        n3 = (MAG_W+1)'(an2_r) + (MAG_W+1)'(ad2_r);
        d3 = MAG_W'(ad2_r);
      end
      CMD_DEC: begin
        n3 = (MAG_W+1)'(an2_r) - (MAG_W+1)'(ad2_r);
        d3 = MAG_W'(ad2_r);
      end
      default: begin
        n3 = '0;
        d3 = MAG_W'(1);
      end
    endcase

    diff3 = {p_ab_r[MAG_W-1], p_ab_r} - {p_ba_r[MAG_W-1], p_ba_r};
    if (cmd2_r != CMD_CMP || diff3 == '0) begin
      cmp3 = CMP_EQ;
    end else if (diff3[MAG_W] ^ ad2_r[FIELD_W-1] ^ bd2_r[FIELD_W-1]) begin
      cmp3 = CMP_LT;
    end else begin
      cmp3 = CMP_GT;
    end

    nabs3 = n3[MAG_W] ? -n3 : n3;
    dabs3 = d3[MAG_W-1] ? -d3 : d3;

    if (err3) begin
      sb3_nxt = '{neg: 1'b0, cmp: CMP_EQ, status: 1'b1};
      n3_nxt  = '0;
      d3_nxt  = '0;
      u3_nxt  = '0;
      w3_nxt  = MAG_W'(1);
    end else begin
      sb3_nxt = '{neg: n3[MAG_W] ^ d3[MAG_W-1], cmp: cmp3, status: 1'b0};
      n3_nxt  = nabs3[MAG_W-1:0];
      d3_nxt  = dabs3;
      u3_nxt  = red3 ? nabs3[MAG_W-1:0] : '0;
      w3_nxt  = red3 ? dabs3 : MAG_W'(1);
    end
  end

  logic             v3_r;
  sb_t              sb3_r;
  logic [MAG_W-1:0] u3_r, w3_r, n3_r, d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r <= sb3_nxt;
      u3_r  <= u3_nxt;
      w3_r  <= w3_nxt;
      n3_r  <= n3_nxt;
      d3_r  <= d3_nxt;
    end
  end

  logic             g_valid;
  sb_t              g_sb;
  logic [MAG_W-1:0] g_v, g_n, g_d;

  rau_gcd u_gcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .in_sb    (sb3_r),
    .in_u     (u3_r),
    .in_v     (w3_r),
    .in_n     (n3_r),
    .in_d     (d3_r),
    .out_valid(g_valid),
    .out_sb   (g_sb),
    .out_v    (g_v),
    .out_n    (g_n),
    .out_d    (g_d)
  );

  logic             q_valid;
  sb_t              q_sb;
  logic [MAG_W-1:0] q_n, q_d;

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (g_valid),
    .in_sb    (g_sb),
    .in_v     (g_v),
    .in_n     (g_n),
    .in_d     (g_d),
    .out_valid(q_valid),
    .out_sb   (q_sb),
    .out_nq   (q_n),
    .out_dq   (q_d)
  );

  // output register
  logic                 out_vld_r;
  logic [RES_NUM_W-1:0] res_num_r;
  logic [DEN_W-1:0]     res_den_r;
  logic [1:0]           cmp_r;
  logic                 status_r;
  logic [RES_NUM_W-1:0] num_ext;

  assign num_ext = {2'b00, q_n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_num_r <= q_sb.neg ? -num_ext : num_ext;
      res_den_r <= q_d[DEN_W-1:0];
      cmp_r     <= q_sb.cmp;
      status_r  <= q_sb.status;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, status_r, cmp_r, res_den_r, res_num_r};

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r |-> res_num_r == '0 && res_den_r == '0 && cmp_r == CMP_EQ)
    else $error("error beat with nonzero fields");
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !status_r |-> res_den_r != '0)
    else $error("zero denominator on ok beat");
  a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cmp_r == CMP_EQ || cmp_r == CMP_LT || cmp_r == CMP_GT)
    else $error("bad compare code");
  a_gcd_div: assert property (@(posedge clk) disable iff (!rst_n)
    g_valid |-> g_v != '0)
    else $error("zero divisor into divider");
`endif

endmodule

// ===== sv/rau_gcd.sv =====
`timescale 1ns / 1ps
module rau_gcd (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  rau_pkg::sb_t             in_sb,
  input  logic [rau_pkg::MAG_W-1:0] in_u,
  input  logic [rau_pkg::MAG_W-1:0] in_v,
  input  logic [rau_pkg::MAG_W-1:0] in_n,
  input  logic [rau_pkg::MAG_W-1:0] in_d,
  output logic                     out_valid,
  output rau_pkg::sb_t             out_sb,
  output logic [rau_pkg::MAG_W-1:0] out_v,
  output logic [rau_pkg::MAG_W-1:0] out_n,
  output logic [rau_pkg::MAG_W-1:0] out_d
);
  import rau_pkg::*;

  logic             vld_r [0:GCD_STEPS];
  sb_t              sb_r  [0:GCD_STEPS];
  logic [MAG_W-1:0] u_r   [0:GCD_STEPS];
  logic [MAG_W-1:0] v_r   [0:GCD_STEPS];
  logic [MAG_W-1:0] n_r   [0:GCD_STEPS];
  logic [MAG_W-1:0] d_r   [0:GCD_STEPS];

  always_comb begin
    vld_r[0] = in_valid;
    sb_r[0]  = in_sb;
    u_r[0]   = in_u;
    v_r[0]   = in_v;
    n_r[0]   = in_n;
    d_r[0]   = in_d;
  end

  // one binary gcd step per stage; common factors of two leave n and d too
  for (genvar i = 1; i <= GCD_STEPS; i++) begin : g_step
    logic [MAG_W-1:0] u_nxt, v_nxt, n_nxt, d_nxt;

    always_comb begin
      u_nxt = u_r[i-1];
      v_nxt = v_r[i-1];
      n_nxt = n_r[i-1];
      d_nxt = d_r[i-1];
      priority if (u_r[i-1] == '0) begin
      end else if (!u_r[i-1][0] && !v_r[i-1][0]) begin
        u_nxt = u_r[i-1] >> 1;
        v_nxt = v_r[i-1] >> 1;
        n_nxt = n_r[i-1] >> 1;
        d_nxt = d_r[i-1] >> 1;
      end else if (!u_r[i-1][0]) begin
        u_nxt = u_r[i-1] >> 1;
      end else if (!v_r[i-1][0]) begin
        v_nxt = v_r[i-1] >> 1;
      end else if (u_r[i-1] >= v_r[i-1]) begin
        u_nxt = (u_r[i-1] - v_r[i-1]) >> 1;
      end else begin
        v_nxt = (v_r[i-1] - u_r[i-1]) >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i] <= sb_r[i-1];
        u_r[i]  <= u_nxt;
        v_r[i]  <= v_nxt;
        n_r[i]  <= n_nxt;
        d_r[i]  <= d_nxt;
      end
    end
  end

  assign out_valid = vld_r[GCD_STEPS];
  assign out_sb    = sb_r[GCD_STEPS];
  assign out_v     = v_r[GCD_STEPS];
  assign out_n     = n_r[GCD_STEPS];
  assign out_d     = d_r[GCD_STEPS];

endmodule

// ===== sv/rau_div.sv =====
`timescale 1ns / 1ps
module rau_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  rau_pkg::sb_t             in_sb,
  input  logic [rau_pkg::MAG_W-1:0] in_v,
  input  logic [rau_pkg::MAG_W-1:0] in_n,
  input  logic [rau_pkg::MAG_W-1:0] in_d,
  output logic                     out_valid,
  output rau_pkg::sb_t             out_sb,
  output logic [rau_pkg::MAG_W-1:0] out_nq,
  output logic [rau_pkg::MAG_W-1:0] out_dq
);
  import rau_pkg::*;

  logic             vld_r [0:DIV_STEPS];
  sb_t              sb_r  [0:DIV_STEPS];
  logic [MAG_W-1:0] v_r   [0:DIV_STEPS];
  logic [MAG_W-1:0] nq_r  [0:DIV_STEPS];
  logic [MAG_W-1:0] nr_r  [0:DIV_STEPS];
  logic [MAG_W-1:0] dq_r  [0:DIV_STEPS];
  logic [MAG_W-1:0] dr_r  [0:DIV_STEPS];

  always_comb begin
    vld_r[0] = in_valid;
    sb_r[0]  = in_sb;
    v_r[0]   = in_v;
    nq_r[0]  = in_n;
    nr_r[0]  = '0;
    dq_r[0]  = in_d;
    dr_r[0]  = '0;
  end

  // restoring division, one quotient bit per stage for both dividends
  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    logic [MAG_W:0]   nt, dt;
    logic             nb, db;
    logic [MAG_W-1:0] nr_nxt, dr_nxt;

    always_comb begin
      nt = {nr_r[i-1], nq_r[i-1][MAG_W-1]};
      dt = {dr_r[i-1], dq_r[i-1][MAG_W-1]};
      nb = (nt >= {1'b0, v_r[i-1]});
      db = (dt >= {1'b0, v_r[i-1]});
      nr_nxt = nb ? MAG_W'(nt - {1'b0, v_r[i-1]}) : nt[MAG_W-1:0];
      dr_nxt = db ? MAG_W'(dt - {1'b0, v_r[i-1]}) : dt[MAG_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i] <= sb_r[i-1];
        v_r[i]  <= v_r[i-1];
        nr_r[i] <= nr_nxt;
        dr_r[i] <= dr_nxt;
        nq_r[i] <= {nq_r[i-1][MAG_W-2:0], nb};
        dq_r[i] <= {dq_r[i-1][MAG_W-2:0], db};
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS];
  assign out_sb    = sb_r[DIV_STEPS];
  assign out_nq    = nq_r[DIV_STEPS];
  assign out_dq    = dq_r[DIV_STEPS];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // status in the top bit, numerator in the low bits, as on out_tdata
  typedef struct packed {
    logic        status;
    logic [1:0]  cmp;
    logic [30:0] den;
    logic [33:0] num;
  } frac_res_t;

  frac_res_t expected_q[$];
  int mismatches;
  int idle_pct;
  int stall_pct;
  bit failed;
  longint cycles = 0;

  localparam longint CYCLE_LIMIT = 400000;

  rational_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t make_frac(longint n, longint d, bit reduce);
    frac_res_t r;
    longint unsigned g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (reduce) begin
      g = gcd64(abs64(n), d);
      if (g > 1) begin
        n = n / longint'(g);
        d = d / longint'(g);
      end
    end
    r.num = n[33:0];
    r.den = d[30:0];
    r.cmp = CMP_EQ;
    r.status = 1'b0;
    return r;
  endfunction

  function automatic frac_res_t predict_frac(logic [2:0] cmd, logic signed [15:0] an16,
                                             logic signed [15:0] ad16,
                                             logic signed [15:0] bn16,
                                             logic signed [15:0] bd16);
    frac_res_t r;
    longint an, ad, bn, bd, l, rr;
    an = an16; ad = ad16; bn = bn16; bd = bd16;
    r = '0;
    if (cmd == CMD_RSV || ad == 0 || (cmd <= CMD_CMP && bd == 0) ||
        (cmd == CMD_DIV && bn == 0)) begin
      r.status = 1'b1;
      return r;
    end
    case (cmd)
      CMD_ADD: r = make_frac(an * bd + bn * ad, ad * bd, 1'b1);
      CMD_SUB: r = make_frac(an * bd - bn * ad, ad * bd, 1'b1);
      CMD_MUL: r = make_frac(an * bn, ad * bd, 1'b1);
      CMD_DIV: r = make_frac(an * bd, ad * bn, 1'b1);
      CMD_CMP: begin
        if (ad < 0) begin
          an = -an;
          ad = -ad;
        end
        if (bd < 0) begin
          bn = -bn;
          bd = -bd;
        end
        l = an * bd;
        rr = bn * ad;
        r.num = '0;
        r.den = 31'd1;
        r.cmp = (l == rr) ? CMP_EQ : ((l < rr) ? CMP_LT : CMP_GT);
      end
      CMD_INC: r = make_frac(an + ad, ad, 1'b0);
      default: r = make_frac(an - ad, ad, 1'b0);
    endcase
    return r;
  endfunction

  task automatic send_frac(logic [2:0] cmd, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_tdata = '0;
    in_tdata[66:0] = {bd, bn, ad, an, cmd};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_frac(cmd, an, ad, bn, bd));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(16)) - 8);
      3: return 16'(int'($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [2:0] c;
    for (int i = 0; i < 8; i++) begin
      c = i[2:0];
      send_frac(c, 16'd3, 16'd4, 16'd5, 16'hfffa);
    end
    send_frac(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_frac(CMD_MUL, 16'h7fff, 16'd1, 16'h7fff, 16'd1);
    send_frac(CMD_DIV, 16'h8000, 16'd1, 16'd1, 16'h7fff);
    send_frac(CMD_DIV, 16'd2, 16'd3, 16'd0, 16'd5);
    send_frac(CMD_ADD, 16'd1, 16'd0, 16'd1, 16'd2);
    send_frac(CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd0);
    send_frac(CMD_INC, 16'd1, 16'd0, 16'd1, 16'd0);
    send_frac(CMD_DEC, 16'd5, 16'hfffd, 16'd0, 16'd0);
    send_frac(CMD_SUB, 16'd2, 16'd4, 16'd1, 16'd2);
    send_frac(CMD_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
    send_frac(CMD_CMP, 16'hffff, 16'h8000, 16'd1, 16'h7fff);
    send_frac(CMD_CMP, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff);
    send_frac(CMD_INC, 16'h7fff, 16'h7fff, 16'd0, 16'd0);
    send_frac(CMD_DEC, 16'h8000, 16'h7fff, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_random(int n, int ip, int sp);
    logic [2:0] c;
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(19) == 0) ? CMD_RSV : 3'($urandom_range(6));
      send_frac(c, rand_field(), rand_field(), rand_field(), rand_field());
    end
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    frac_res_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[67:0];
      if (expected_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: num %h/%h den %h/%h cmp %h/%h st %b/%b (exp/act)",
                     want.num, got.num, want.den, got.den, want.cmp, got.cmp,
                     want.status, got.status);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    failed = 1'b0;
    mismatches = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 73, 0);
    test_random(150, 0, 73);
    test_random(150, 36, 36);
    if (expected_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
